FILE: src/vptd_pkg.sv
`timescale 1ns / 1ps
// Package for the virtual periodic tick divider: sizes, command and status codes,
// result struct and the period mask function. No dependencies.
package vptd_pkg;

  localparam int CHANNELS  = 8;
  localparam int REAL_RATE = 1024;
  localparam int TICK_BITS = 10;
  localparam int EXP_BITS  = 4;
  localparam int CH_BITS   = 3;
  localparam int RATE_BITS = 16;
  localparam int FLAG_BITS = 8;

  localparam logic [EXP_BITS-1:0] RESET_EXP = 4'd4;
  localparam logic [EXP_BITS-1:0] OPEN_EXP  = 4'd1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [FLAG_BITS-1:0] pending_flags;
  } result_t;

  // Low-bit mask of the count that must be zero for a channel at rate 2^e.
  function automatic logic [TICK_BITS-1:0] period_mask(input logic [EXP_BITS-1:0] e);
    int unsigned period;
    period = REAL_RATE >> e;
    if (period == 0) begin
      period = 1;
    end
    return TICK_BITS'(period - 1);
  endfunction

endpackage

FILE: src/vptd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tick divider's command and result streams.
// Depends on vptd_pkg.
interface vptd_in_if
  import vptd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  logic [CH_BITS-1:0]   channel;
  logic [RATE_BITS-1:0] rate_wanted;

  modport source (output valid, output cmd, output channel, output rate_wanted, input ready);
  modport sink   (input valid, input cmd, input channel, input rate_wanted, output ready);
endinterface

interface vptd_out_if
  import vptd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [FLAG_BITS-1:0] pending_flags;

  modport source (output valid, output status, output pending_flags, input ready);
  modport sink   (input valid, input status, input pending_flags, output ready);
endinterface

FILE: src/virtual_periodic_tick_divider.sv
`timescale 1ns / 1ps
// Top level of the virtual periodic tick divider: channel state, per-command update
// and a two-entry result buffer. Depends on vptd_pkg and vptd_if.
//
//   channel   dir   payload                        handshake
//   in_ch     in    cmd, channel, rate_wanted      valid/ready
//   out_ch    out   status, pending_flags          valid/ready
//
// One transaction per cycle while in_ch is ready; each result goes to a register (out or skid).
// State updates in the accepting cycle, so the next transaction sees it at once.
// Result register plus skid register: input stays ready while one result waits,
// and drops ready only when both hold a result.
// rst_n is synchronous, active low; it restores rates to 16 Hz and clears flags.
module virtual_periodic_tick_divider
  import vptd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  vptd_in_if.sink     in_ch,
  vptd_out_if.source  out_ch
);

  logic [TICK_BITS-1:0]               tick_count_r, tick_count_nxt;
  logic [CHANNELS-1:0][EXP_BITS-1:0]  rate_exp_r, rate_exp_nxt;
  logic [CHANNELS-1:0]                pending_r, pending_nxt;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  result_t result;

  logic                in_acc, out_take;
  logic                ch_ok, write_ok;
  logic [EXP_BITS-1:0] write_exp;
  status_t             status;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;

  assign ch_ok = 32'(in_ch.channel) < CHANNELS;

  always_comb begin
    write_exp = '0;
    for (int i = 0; i < RATE_BITS; i++) begin
      if (in_ch.rate_wanted[i]) begin
        write_exp = EXP_BITS'(i);
      end
    end
  end

  assign write_ok = ch_ok && (in_ch.rate_wanted >= RATE_BITS'(2)) &&
                    ((in_ch.rate_wanted & (in_ch.rate_wanted - RATE_BITS'(1))) == '0) &&
                    (32'(in_ch.rate_wanted) <= REAL_RATE);

  always_comb begin
    tick_count_nxt = tick_count_r;
    rate_exp_nxt   = rate_exp_r;
    pending_nxt    = pending_r;
    status         = ST_OK;
    case (in_ch.cmd)
      CMD_TICK: begin
        tick_count_nxt = tick_count_r + TICK_BITS'(1);
        for (int c = 0; c < CHANNELS; c++) begin
          if ((tick_count_nxt & period_mask(rate_exp_r[c])) == '0) begin
            pending_nxt[c] = 1'b1;
          end
        end
      end
      CMD_OPEN: begin
        if (ch_ok) begin
          pending_nxt[in_ch.channel]  = 1'b0;
          rate_exp_nxt[in_ch.channel] = OPEN_EXP;
        end
      end
      CMD_WRITE: begin
        if (write_ok) begin
          rate_exp_nxt[in_ch.channel] = write_exp;
        end else begin
          status = ST_REJECT;
        end
      end
      CMD_READ: begin
        if (ch_ok && pending_r[in_ch.channel]) begin
          pending_nxt[in_ch.channel] = 1'b0;
        end else begin
          status = ST_EMPTY;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign result.status        = status;
  assign result.pending_flags = FLAG_BITS'(pending_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      rate_exp_r   <= {CHANNELS{RESET_EXP}};
      pending_r    <= '0;
    end else if (in_acc) begin
      tick_count_r <= tick_count_nxt;
      rate_exp_r   <= rate_exp_nxt;
      pending_r    <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (in_acc) begin
      skid_data_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_data_r.status;
  assign out_ch.pending_flags = out_data_r.pending_flags;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_reject_keeps_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_WRITE && !write_ok) |=> $stable(rate_exp_r))
    else $error("rejected rate write changed a rate");

  a_tick_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_TICK) |=> ((pending_r & $past(pending_r)) == $past(pending_r)))
    else $error("tick cleared a pending flag");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_valid_r) |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

FILE: tb/sv/vptd_checker.sv
`timescale 1ns / 1ps
// Result checker for the virtual periodic tick divider: watches both channels, predicts
// status and pending flags per command transaction and compares. Depends on vptd_pkg, vptd_if.
module vptd_checker
  import vptd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  vptd_in_if   in_ch,
  vptd_out_if  out_ch,
  output int   fail_count,
  output int   results_due
);

  logic [TICK_BITS-1:0] tick_count;
  logic [EXP_BITS-1:0]  rate_exp [CHANNELS];
  logic [CHANNELS-1:0]  flags;
  result_t              status_flags_q[$];
  result_t              want;
  int                   mismatches = 0;
  int                   due = 0;

  assign fail_count  = mismatches;
  assign results_due = due;

  function automatic int unsigned period_ticks(input logic [EXP_BITS-1:0] e);
    int unsigned p;
    p = REAL_RATE >> e;
    return (p == 0) ? 1 : p;
  endfunction

  task automatic apply_command(input cmd_t cmd, input logic [CH_BITS-1:0] ch,
                               input logic [RATE_BITS-1:0] rate);
    result_t     r;
    int unsigned e;
    bit          known;
    known    = (int'(ch) < CHANNELS);
    r.status = ST_OK;
    case (cmd)
      CMD_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          if ((int'(tick_count) % period_ticks(rate_exp[c])) == 0) begin
            flags[c] = 1'b1;
          end
        end
      end
      CMD_OPEN: begin
        if (known) begin
          flags[ch]    = 1'b0;
          rate_exp[ch] = OPEN_EXP;
        end
      end
      CMD_WRITE: begin
        if (known && rate >= 2 && (rate & (rate - 1)) == 0 && rate <= REAL_RATE) begin
          e = 0;
          for (int i = 0; i < RATE_BITS; i++) begin
            if (rate[i]) begin
              e = i;
            end
          end
          rate_exp[ch] = e[EXP_BITS-1:0];
        end else begin
          r.status = ST_REJECT;
        end
      end
      default: begin
        if (known && flags[ch]) begin
          flags[ch] = 1'b0;
        end else begin
          r.status = ST_EMPTY;
        end
      end
    endcase
    r.pending_flags = FLAG_BITS'(flags);
    status_flags_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_count = '0;
      flags      = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rate_exp[c] = RESET_EXP;
      end
      status_flags_q.delete();
      due = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_flags_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d flags %02h",
                   $time, out_ch.status, out_ch.pending_flags);
          mismatches++;
        end else begin
          want = status_flags_q.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.pending_flags !== want.pending_flags) begin
            $display("%0t: pending_flags mismatch, expected %02h, actual %02h",
                     $time, want.pending_flags, out_ch.pending_flags);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_command(in_ch.cmd, in_ch.channel, in_ch.rate_wanted);
      end
      due = status_flags_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the tick divider testbench: clock, reset, command stimulus with random gaps and
// result back-pressure, verdict. Depends on vptd_pkg, vptd_if, the block and vptd_checker.
module tb
  import vptd_pkg::*;
();

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_due;
  int   accepted_count = 0;
  bit   sender_burst = 1'b0;
  bit   receiver_burst = 1'b0;
  bit   held_off = 1'b0;
  int   stall_left = 0;

  vptd_in_if  in_ch ();
  vptd_out_if out_ch ();

  virtual_periodic_tick_divider uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vptd_checker flag_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_command(input cmd_t cmd, input logic [CH_BITS-1:0] ch,
                              input logic [RATE_BITS-1:0] rate);
    int gap;
    if ($urandom_range(0, 149) == 0) begin
      sender_burst = !sender_burst;
    end
    gap = pick_gap(sender_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.channel     <= ch;
    in_ch.rate_wanted <= rate;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accepted_count++;
  endtask

  initial begin
    int                   r;
    int                   spin;
    logic [CH_BITS-1:0]   ch;
    logic [RATE_BITS-1:0] rate;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_TICK;
    in_ch.channel     <= '0;
    in_ch.rate_wanted <= '0;
    rst_n             <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_command(CMD_READ,  3'd0, 16'h0000);
    send_command(CMD_WRITE, 3'd0, 16'd0);
    send_command(CMD_WRITE, 3'd1, 16'd1);
    send_command(CMD_WRITE, 3'd2, 16'd3);
    send_command(CMD_WRITE, 3'd3, 16'd2048);
    send_command(CMD_WRITE, 3'd4, 16'hFFFF);
    send_command(CMD_WRITE, 3'd5, 16'h8000);
    send_command(CMD_WRITE, 3'd7, 16'd1024);
    send_command(CMD_WRITE, 3'd6, 16'd2);
    send_command(CMD_OPEN,  3'd1, 16'hFFFF);
    send_command(CMD_TICK,  3'd7, 16'h5555);
    send_command(CMD_READ,  3'd7, 16'hAAAA);
    send_command(CMD_READ,  3'd7, 16'h0000);
    send_command(CMD_TICK,  3'd0, 16'h0000);
    send_command(CMD_TICK,  3'd5, 16'hFFFF);
    send_command(CMD_WRITE, 3'd0, 16'd512);
    send_command(CMD_TICK,  3'd2, 16'h1234);
    send_command(CMD_TICK,  3'd6, 16'hFEDC);
    send_command(CMD_OPEN,  3'd7, 16'h0000);
    send_command(CMD_READ,  3'd0, 16'hFFFF);
    send_command(CMD_READ,  3'd7, 16'h0000);
    send_command(CMD_WRITE, 3'd2, 16'd4);
    send_command(CMD_OPEN,  3'd0, 16'h00FF);
    send_command(CMD_TICK,  3'd1, 16'hFF00);

    for (int n = 0; n < 1300; n++) begin
      r    = $urandom_range(0, 99);
      ch   = CH_BITS'($urandom_range(0, CHANNELS - 1));
      rate = RATE_BITS'($urandom_range(0, 65535));
      if (r < 80) begin
        send_command(CMD_TICK, ch, rate);
      end else if (r < 91) begin
        send_command(CMD_READ, ch, rate);
      end else if (r < 97) begin
        if ($urandom_range(0, 3) != 0) begin
          rate = 16'd1 << $urandom_range(1, 10);
        end
        send_command(CMD_WRITE, ch, rate);
      end else begin
        send_command(CMD_OPEN, ch, rate);
      end
    end
    in_ch.valid <= 1'b0;

    for (spin = 0; spin < 20000 && results_due != 0; spin++) @(negedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && accepted_count >= 300) begin
        // hold off results long enough to fill the block and stall its input
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 149) == 0) begin
          receiver_burst = !receiver_burst;
        end
        stall_left = pick_gap(receiver_burst);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
src/vptd_pkg.sv
src/vptd_if.sv
src/virtual_periodic_tick_divider.sv
tb/sv/vptd_checker.sv
tb/sv/tb.sv
